[sv/qslerp_pkg.sv]
// Shared types, constants and the arctangent table for the quaternion slerp pipeline.
package qslerp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int FW        = 18;
	localparam int CW        = 34;
	localparam int SQW       = 34;
	localparam int SQ_STEPS  = 17;
	localparam int DIV_STEPS = 18;
	localparam int DW        = 34;
	localparam int ANG_SHIFT = 14;

	localparam logic [16:0]          ONE  = 17'h10000;
	localparam logic [17:0]          TWO  = 18'h20000;
	localparam logic signed [CW-1:0] KINV = 34'sd652032874;

	typedef logic signed [FW-1:0] fld_t;
	typedef logic signed [FW:0]   fldn_t;

	typedef struct packed {
		fld_t  [3:0] p;
		fldn_t [3:0] qn;
		logic  [16:0] t;
		logic  [17:0] k0l;
		logic  [17:0] k1l;
		logic         tr;
		logic  [16:0] cc;
		logic  [16:0] s;
	} side_t;

	localparam int SIDE_W = $bits(side_t);

	function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] k);
		logic signed [CW-1:0] r;
		unique case (k)
			5'd0:  r = 34'sh3243F6A8;
			5'd1:  r = 34'sh1DAC6705;
			5'd2:  r = 34'sh0FADBAFC;
			5'd3:  r = 34'sh07F56EA6;
			5'd4:  r = 34'sh03FEAB76;
			5'd5:  r = 34'sh01FFD55B;
			5'd6:  r = 34'sh00FFFAAA;
			5'd7:  r = 34'sh007FFF55;
			5'd8:  r = 34'sh003FFFEA;
			5'd9:  r = 34'sh001FFFFD;
			5'd10: r = 34'sh000FFFFF;
			5'd11: r = 34'sh0007FFFF;
			5'd12: r = 34'sh0003FFFF;
			5'd13: r = 34'sh0001FFFF;
			5'd14: r = 34'sh0000FFFF;
			5'd15: r = 34'sh00007FFF;
			5'd16: r = 34'sh00003FFF;
			5'd17: r = 34'sh00001FFF;
			5'd18: r = 34'sh00000FFF;
			5'd19: r = 34'sh000007FF;
			5'd20: r = 34'sh000003FF;
			5'd21: r = 34'sh000001FF;
			5'd22: r = 34'sh000000FF;
			5'd23: r = 34'sh0000007F;
			5'd24: r = 34'sh0000003F;
			5'd25: r = 34'sh0000001F;
			5'd26: r = 34'sh0000000F;
			5'd27: r = 34'sh00000008;
			5'd28: r = 34'sh00000004;
			5'd29: r = 34'sh00000002;
			5'd30: r = 34'sh00000001;
			5'd31: r = 34'sh00000000;
		endcase
		return r;
	endfunction

	function automatic logic [DW-1:0] sin_to_num(input logic signed [CW-1:0] y);
		logic [31:0] c;
		if (y < 0) begin
			c = '0;
		end else if (y > 34'sh080000000) begin
			c = 32'h80000000;
		end else begin
			c = y[31:0];
		end
		return {c, 2'b00};
	endfunction

endpackage

[sv/qslerp_sqrt.sv]
// Pipelined bit-serial floor square root, one result bit per stage.
module qslerp_sqrt #(
	parameter int PW = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [qslerp_pkg::SQW-1:0]   in_rad,
	input  logic [PW-1:0]                in_side,
	output logic                         out_valid,
	output logic [16:0]                  out_root,
	output logic [PW-1:0]                out_side
);
	import qslerp_pkg::*;

	logic [SQ_STEPS-1:0] v_s;
	logic [SQW-1:0]      rem_s  [SQ_STEPS];
	logic [SQW-1:0]      res_s  [SQ_STEPS];
	logic [SQW-1:0]      rem_n  [SQ_STEPS];
	logic [SQW-1:0]      res_n  [SQ_STEPS];
	logic [SQW-1:0]      rem_p  [SQ_STEPS];
	logic [SQW-1:0]      res_p  [SQ_STEPS];
	logic [PW-1:0]       side_s [SQ_STEPS];

	always_comb begin
		logic [SQW-1:0] bit_v;
		logic [SQW-1:0] trial;
		rem_p[0] = in_rad;
		res_p[0] = '0;
		for (int j = 1; j < SQ_STEPS; j++) begin
			rem_p[j] = rem_s[j-1];
			res_p[j] = res_s[j-1];
		end
		for (int j = 0; j < SQ_STEPS; j++) begin
			bit_v = SQW'(1) << (2 * (SQ_STEPS - 1 - j));
			trial = res_p[j] + bit_v;
			if (rem_p[j] >= trial) begin
				rem_n[j] = rem_p[j] - trial;
				res_n[j] = (res_p[j] >> 1) + bit_v;
			end else begin
				rem_n[j] = rem_p[j];
				res_n[j] = res_p[j] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[SQ_STEPS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int j = 1; j < SQ_STEPS; j++) begin
				side_s[j] <= side_s[j-1];
			end
			for (int j = 0; j < SQ_STEPS; j++) begin
				rem_s[j] <= rem_n[j];
				res_s[j] <= res_n[j];
			end
		end
	end

	assign out_valid = v_s[SQ_STEPS-1];
	assign out_root  = res_s[SQ_STEPS-1][16:0];
	assign out_side  = side_s[SQ_STEPS-1];

endmodule

[sv/qslerp_cordic.sv]
// Pipelined CORDIC, one micro-rotation per stage, vectoring or rotation mode.
module qslerp_cordic #(
	parameter int STEPS  = 18,
	parameter bit VECTOR = 1'b0,
	parameter int PW     = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic signed [qslerp_pkg::CW-1:0]  in_x,
	input  logic signed [qslerp_pkg::CW-1:0]  in_y,
	input  logic signed [qslerp_pkg::CW-1:0]  in_z,
	input  logic [PW-1:0]                     in_side,
	output logic                              out_valid,
	output logic signed [qslerp_pkg::CW-1:0]  out_y,
	output logic signed [qslerp_pkg::CW-1:0]  out_z,
	output logic [PW-1:0]                     out_side
);
	import qslerp_pkg::*;

	logic [STEPS-1:0]     v_s;
	logic signed [CW-1:0] x_s [STEPS];
	logic signed [CW-1:0] y_s [STEPS];
	logic signed [CW-1:0] z_s [STEPS];
	logic signed [CW-1:0] x_p [STEPS];
	logic signed [CW-1:0] y_p [STEPS];
	logic signed [CW-1:0] z_p [STEPS];
	logic signed [CW-1:0] x_n [STEPS];
	logic signed [CW-1:0] y_n [STEPS];
	logic signed [CW-1:0] z_n [STEPS];
	logic [PW-1:0]        side_s [STEPS];

	always_comb begin
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		logic signed [CW-1:0] at;
		logic                 cw;
		x_p[0] = in_x;
		y_p[0] = in_y;
		z_p[0] = in_z;
		for (int i = 1; i < STEPS; i++) begin
			x_p[i] = x_s[i-1];
			y_p[i] = y_s[i-1];
			z_p[i] = z_s[i-1];
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x_p[i] >>> i;
			ys = y_p[i] >>> i;
			at = atan_q30(5'(i));
			cw = VECTOR ? (y_p[i] > 0) : (z_p[i] < 0);
			if (cw) begin
				x_n[i] = x_p[i] + ys;
				y_n[i] = y_p[i] - xs;
				z_n[i] = z_p[i] + at;
			end else begin
				x_n[i] = x_p[i] - ys;
				y_n[i] = y_p[i] + xs;
				z_n[i] = z_p[i] - at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[STEPS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int i = 1; i < STEPS; i++) begin
				side_s[i] <= side_s[i-1];
			end
			for (int i = 0; i < STEPS; i++) begin
				x_s[i] <= x_n[i];
				y_s[i] <= y_n[i];
				z_s[i] <= z_n[i];
			end
		end
	end

	assign out_valid = v_s[STEPS-1];
	assign out_y     = y_s[STEPS-1];
	assign out_z     = z_s[STEPS-1];
	assign out_side  = side_s[STEPS-1];

endmodule

[sv/qslerp_div.sv]
// Pipelined restoring divider for the slerp weights, saturated at two.
module qslerp_div #(
	parameter int PW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [qslerp_pkg::DW-1:0]   in_num,
	input  logic [16:0]                 in_den,
	input  logic [PW-1:0]               in_side,
	output logic                        out_valid,
	output logic [17:0]                 out_quo,
	output logic [PW-1:0]               out_side
);
	import qslerp_pkg::*;

	logic [DIV_STEPS-1:0] v_s;
	logic [DIV_STEPS-1:0] ovf_s;
	logic [DW-1:0]        rem_s [DIV_STEPS];
	logic [DW-1:0]        rem_p [DIV_STEPS];
	logic [DW-1:0]        rem_n [DIV_STEPS];
	logic [17:0]          quo_s [DIV_STEPS];
	logic [17:0]          quo_p [DIV_STEPS];
	logic [17:0]          quo_n [DIV_STEPS];
	logic [16:0]          den_s [DIV_STEPS];
	logic [16:0]          den_p [DIV_STEPS];
	logic [PW-1:0]        side_s [DIV_STEPS];
	logic                 ovf_in;

	assign ovf_in = (in_num >> DIV_STEPS) >= DW'(in_den);

	always_comb begin
		logic [DW-1:0] d;
		rem_p[0] = in_num;
		quo_p[0] = '0;
		den_p[0] = in_den;
		for (int j = 1; j < DIV_STEPS; j++) begin
			rem_p[j] = rem_s[j-1];
			quo_p[j] = quo_s[j-1];
			den_p[j] = den_s[j-1];
		end
		for (int j = 0; j < DIV_STEPS; j++) begin
			d = DW'(den_p[j]) << (DIV_STEPS - 1 - j);
			if (rem_p[j] >= d) begin
				rem_n[j] = rem_p[j] - d;
				quo_n[j] = {quo_p[j][16:0], 1'b1};
			end else begin
				rem_n[j] = rem_p[j];
				quo_n[j] = {quo_p[j][16:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DIV_STEPS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			ovf_s     <= {ovf_s[DIV_STEPS-2:0], ovf_in};
			for (int j = 1; j < DIV_STEPS; j++) begin
				side_s[j] <= side_s[j-1];
			end
			for (int j = 0; j < DIV_STEPS; j++) begin
				rem_s[j] <= rem_n[j];
				quo_s[j] <= quo_n[j];
				den_s[j] <= den_p[j];
			end
		end
	end

	assign out_valid = v_s[DIV_STEPS-1];
	assign out_quo   = (ovf_s[DIV_STEPS-1] || quo_s[DIV_STEPS-1] > TWO) ? TWO
		: quo_s[DIV_STEPS-1];
	assign out_side  = side_s[DIV_STEPS-1];

endmodule

[sv/quaternion_slerp.sv]
// Quaternion spherical linear interpolation, top level.
// One beat is taken every cycle while the output is not stalled, and each gives one result beat
// after passing three front stages (dot products, cosine, radicand), a 17-stage square root, a
// vectoring CORDIC for the angle, one angle-scaling multiply stage, two rotation CORDICs for
// the sines, two 18-stage dividers for the weights and two output stages (multiply, round
// and saturate). All stages advance together; when m_axis_tready is low with a result
// waiting, the whole pipeline holds and s_axis_tready drops. The threshold register may be
// written at any time the block is idle and is taken on every cfg_valid beat.
module quaternion_slerp #(
	parameter int CORDIC_STEPS = 18
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// first_w, first_x, first_y, first_z, second_w, second_x, second_y, second_z, blend
	input  logic [167:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_w, out_x, out_y, out_z
	output logic [71:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [16:0]  cfg_data
);
	import qslerp_pkg::*;

	logic         en;
	logic [16:0]  thr_q;

	logic                v_s1;
	fld_t [3:0]          p_s1;
	fld_t [3:0]          q_s1;
	fld_t                t_s1;
	logic signed [35:0]  prod_s1 [4];

	logic signed [37:0]  dot;
	logic                neg;
	logic [37:0]         dabs;
	logic [21:0]         cval;
	logic                edge_lo;
	logic                edge_hi;
	side_t               side_in;

	logic                v_s2;
	side_t               side_s2;
	logic                v_s3;
	logic [SQW-1:0]      rad_s3;
	side_t               side_s3;

	logic                vq;
	logic [16:0]         root;
	logic [SIDE_W-1:0]   side_q;
	side_t               side_a;

	logic                va;
	logic signed [CW-1:0] w_ang;
	logic [SIDE_W-1:0]   side_w;
	side_t               sw;
	logic signed [51:0]  m_a0;
	logic signed [51:0]  m_a1;

	logic                v_s4;
	logic signed [CW-1:0] a0_s4;
	logic signed [CW-1:0] a1_s4;
	side_t               side_s4;

	logic                vs;
	logic signed [CW-1:0] sin0;
	logic signed [CW-1:0] sin1;
	logic [SIDE_W-1:0]   side_sn;
	side_t               ss;

	logic                vd;
	logic [17:0]         dk0;
	logic [17:0]         dk1;
	logic [SIDE_W-1:0]   side_d;
	side_t               sd;
	logic [17:0]         k0;
	logic [17:0]         k1;

	logic                v_s5;
	logic signed [36:0]  m0_s5 [4];
	logic signed [37:0]  m1_s5 [4];

	logic                v_s6;
	fld_t [3:0]          o_s6;

	assign en            = !v_s6 || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 17'd65529;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= va;
			v_s5 <= vd;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				p_s1[i]    <= $signed(s_axis_tdata[FW*i +: FW]);
				q_s1[i]    <= $signed(s_axis_tdata[FW*(i+4) +: FW]);
				prod_s1[i] <= $signed(s_axis_tdata[FW*i +: FW])
					* $signed(s_axis_tdata[FW*(i+4) +: FW]);
			end
			t_s1 <= $signed(s_axis_tdata[FW*8 +: FW]);
		end
	end

	always_comb begin
		dot     = 38'(prod_s1[0]) + 38'(prod_s1[1]) + 38'(prod_s1[2]) + 38'(prod_s1[3]);
		neg     = dot[37];
		dabs    = neg ? 38'(-dot) : 38'(dot);
		cval    = dabs[37:16];
		edge_lo = t_s1[17] || (t_s1 == '0);
		edge_hi = !t_s1[17] && t_s1[16];
		side_in.p  = p_s1;
		for (int i = 0; i < 4; i++) begin
			side_in.qn[i] = (neg && !edge_lo && !edge_hi) ? -19'(q_s1[i]) : 19'(q_s1[i]);
		end
		side_in.t  = t_s1[16:0];
		priority if (edge_lo) begin
			side_in.k0l = 18'(ONE);
			side_in.k1l = '0;
		end else if (edge_hi) begin
			side_in.k0l = '0;
			side_in.k1l = 18'(ONE);
		end else begin
			side_in.k0l = 18'(ONE) - $unsigned(t_s1);
			side_in.k1l = $unsigned(t_s1);
		end
		side_in.tr = (cval <= 22'(thr_q)) && !edge_lo && !edge_hi;
		side_in.cc = (cval > 22'(ONE)) ? ONE : cval[16:0];
		side_in.s  = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_in;
			side_s3 <= side_s2;
			rad_s3  <= (SQW'(1) << (2 * FRAC_BITS)) - SQW'(side_s2.cc) * SQW'(side_s2.cc);
		end
	end

	qslerp_sqrt #(.PW(SIDE_W)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_rad    (rad_s3),
		.in_side   (side_s3),
		.out_valid (vq),
		.out_root  (root),
		.out_side  (side_q)
	);

	always_comb begin
		side_a    = side_t'(side_q);
		side_a.s  = root;
		side_a.tr = side_a.tr && (root != '0);
	end

	qslerp_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1), .PW(SIDE_W)) u_atan (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vq),
		.in_x      ($signed(CW'(side_a.cc) << ANG_SHIFT)),
		.in_y      ($signed(CW'(root) << ANG_SHIFT)),
		.in_z      ('0),
		.in_side   (side_a),
		.out_valid (va),
		.out_y     (),
		.out_z     (w_ang),
		.out_side  (side_w)
	);

	assign sw   = side_t'(side_w);
	assign m_a0 = $signed({1'b0, ONE - sw.t}) * w_ang;
	assign m_a1 = $signed({1'b0, sw.t}) * w_ang;

	always_ff @(posedge clk) begin
		if (en) begin
			a0_s4   <= CW'(m_a0 >>> FRAC_BITS);
			a1_s4   <= CW'(m_a1 >>> FRAC_BITS);
			side_s4 <= sw;
		end
	end

	qslerp_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0), .PW(SIDE_W)) u_sin0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_x      (KINV),
		.in_y      ('0),
		.in_z      (a0_s4),
		.in_side   (side_s4),
		.out_valid (vs),
		.out_y     (sin0),
		.out_z     (),
		.out_side  (side_sn)
	);

	qslerp_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0), .PW(1)) u_sin1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_x      (KINV),
		.in_y      ('0),
		.in_z      (a1_s4),
		.in_side   (1'b0),
		.out_valid (),
		.out_y     (sin1),
		.out_z     (),
		.out_side  ()
	);

	assign ss = side_t'(side_sn);

	qslerp_div #(.PW(SIDE_W)) u_div0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vs),
		.in_num    (sin_to_num(sin0)),
		.in_den    (ss.s),
		.in_side   (ss),
		.out_valid (vd),
		.out_quo   (dk0),
		.out_side  (side_d)
	);

	qslerp_div #(.PW(1)) u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vs),
		.in_num    (sin_to_num(sin1)),
		.in_den    (ss.s),
		.in_side   (1'b0),
		.out_valid (),
		.out_quo   (dk1),
		.out_side  ()
	);

	assign sd = side_t'(side_d);
	assign k0 = sd.tr ? dk0 : sd.k0l;
	assign k1 = sd.tr ? dk1 : sd.k1l;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				m0_s5[i] <= $signed({1'b0, k0}) * sd.p[i];
				m1_s5[i] <= $signed({1'b0, k1}) * sd.qn[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [38:0] acc;
		logic signed [22:0] sh;
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				acc = 39'(m0_s5[i]) + 39'(m1_s5[i]) + 39'sd32768;
				sh  = 23'(acc >>> FRAC_BITS);
				priority if (sh > 23'sd131071) begin
					o_s6[i] <= 18'sd131071;
				end else if (sh < -23'sd131072) begin
					o_s6[i] <= -18'sd131072;
				end else begin
					o_s6[i] <= sh[17:0];
				end
			end
		end
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = o_s6;

`ifndef NO_ASSERTIONS
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output backpressure");
	a_s5_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && en) |=> m_axis_tvalid)
		else $error("multiply stage beat lost before output");
	a_s1_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && en) |=> v_s2)
		else $error("front stage beat lost");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(v_s1) && $stable(v_s5)))
		else $error("pipeline moved during stall");
`endif

endmodule

[tb/quaternion_slerp_checker.sv]
// Result checker for quaternion_slerp: predicts each blended quaternion and compares it.
module quaternion_slerp_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [167:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [71:0]  m_axis_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [16:0]  cfg_data,
	output int           fail_count,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = 18;

	logic [16:0] lin_thresh;
	logic [71:0] slerp_queue[$];

	function automatic longint fdiv2(longint v, int n);
		if (v >= 0) begin
			return v >>> n;
		end
		return -(((-v) - 1) >>> n) - 1;
	endfunction

	function automatic longint int_root(longint v);
		longint r;
		longint b;
		r = 0;
		for (b = 64'sh4000000000000000; b != 0; b = b >>> 2) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
		end
		return r;
	endfunction

	function automatic longint arctan_step(int k);
		return longint'(qslerp_pkg::atan_q30(k[4:0]));
	endfunction

	function automatic longint vec_angle(longint y, longint x);
		longint z;
		longint dx;
		longint dy;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = fdiv2(y, i & 31);
			dy = fdiv2(x, i & 31);
			if (y > 0) begin
				x += dx; y -= dy; z += arctan_step(i & 31);
			end else begin
				x -= dx; y += dy; z -= arctan_step(i & 31);
			end
		end
		return z;
	endfunction

	function automatic longint rot_sine(longint z);
		longint x;
		longint y;
		longint dx;
		longint dy;
		x = 652032874;
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = fdiv2(y, i & 31);
			dy = fdiv2(x, i & 31);
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan_step(i & 31);
			end else begin
				x += dx; y -= dy; z += arctan_step(i & 31);
			end
		end
		return y;
	endfunction

	function automatic longint blend_weight(longint sa, longint sw);
		longint k;
		if (sa < 0) sa = 0;
		if (sa > (64'sd1 << 31)) sa = 64'sd1 << 31;
		k = (sa <<< 16) / sw;
		return (k > (64'sd2 << 16)) ? (64'sd2 << 16) : k;
	endfunction

	function automatic logic [17:0] sat18(longint v);
		if (v > 131071) v = 131071;
		if (v < -131072) v = -131072;
		return v[17:0];
	endfunction

	function automatic logic [71:0] slerp_predict(logic [167:0] d, logic [16:0] th);
		longint p[4];
		longint q[4];
		longint t, dot, c, k0, k1, s, s30, w;
		logic [71:0] r;
		for (int i = 0; i < 4; i++) begin
			p[i] = longint'($signed(d[18*i +: 18]));
			q[i] = longint'($signed(d[18*(i+4) +: 18]));
		end
		t = longint'($signed(d[144 +: 18]));
		if (t <= 0 || t >= 65536) begin
			for (int i = 0; i < 4; i++) r[18*i +: 18] = sat18(t <= 0 ? p[i] : q[i]);
			return r;
		end
		dot = 0;
		for (int i = 0; i < 4; i++) dot += p[i] * q[i];
		if (dot < 0) begin
			for (int i = 0; i < 4; i++) q[i] = -q[i];
			dot = -dot;
		end
		c = dot >>> 16;
		k0 = 65536 - t;
		k1 = t;
		if (c <= longint'(th)) begin
			if (c > 65536) c = 65536;
			s = int_root(65536 * 65536 - c * c);
			if (s > 0) begin
				s30 = s <<< 14;
				w = vec_angle(s30, c <<< 14);
				k0 = blend_weight(rot_sine(((65536 - t) * w) >>> 16), s30);
				k1 = blend_weight(rot_sine((t * w) >>> 16), s30);
			end
		end
		for (int i = 0; i < 4; i++)
			r[18*i +: 18] = sat18(fdiv2(k0 * p[i] + k1 * q[i] + 32768, 16));
		return r;
	endfunction

	assign pending = slerp_queue.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_thresh <= 17'd65529;
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) lin_thresh <= cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				slerp_queue.push_back(slerp_predict(s_axis_tdata, lin_thresh));
			if (m_axis_tvalid && m_axis_tready) begin
				if (slerp_queue.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					logic [71:0] exp_q;
					int bad;
					exp_q = slerp_queue.pop_front();
					bad = 0;
					for (int i = 0; i < 4; i++)
						if (exp_q[18*i +: 18] !== m_axis_tdata[18*i +: 18]) begin
							$display("%0t: component %0d expected %h actual %h", $time, i,
								exp_q[18*i +: 18], m_axis_tdata[18*i +: 18]);
							bad++;
						end
					if (bad != 0) fail_count <= fail_count + bad;
				end
			end
		end
	end
endmodule

[tb/quaternion_slerp_tb.sv]
// Testbench top for quaternion_slerp: stimulus, idling, register phases and verdict.
module quaternion_slerp_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [167:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [71:0]  m_axis_tdata;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [16:0]  cfg_data = '0;
	int           fail_count;
	int           pending;
	bit           hold_off = 0;
	bit           run_done = 0;

	always #5 clk = ~clk;

	quaternion_slerp uut (.*);
	quaternion_slerp_checker chk (.*);

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	function automatic logic [17:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 18'h1FFFF;
			1: return 18'h20000;
			2: return 18'($urandom_range(0, 65536));
			3: return 18'(-$signed(18'($urandom_range(0, 65536))));
			default: return 18'($urandom);
		endcase
	endfunction

	function automatic logic [17:0] rand_blend();
		case ($urandom_range(0, 7))
			0: return 18'($urandom_range(0, 1)) - 18'd1;
			1: return 18'h10000 + 18'($urandom_range(0, 1));
			2: return 18'($urandom);
			default: return 18'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic logic [167:0] make_item(bit near);
		logic [167:0] d;
		for (int i = 0; i < 8; i++) d[18*i +: 18] = rand_comp();
		if (near) begin
			for (int i = 0; i < 4; i++)
				d[18*(i+4) +: 18] = d[18*i +: 18] + 18'($urandom_range(0, 64)) - 18'd32;
			if ($urandom_range(0, 1)) for (int i = 4; i < 8; i++) d[18*i +: 18] = -d[18*i +: 18];
		end
		d[144 +: 18] = rand_blend();
		return d;
	endfunction

	task automatic send_item(logic [167:0] d);
		int gap;
		gap = gap_len();
		if (gap != 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= d;
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic write_thresh(logic [16:0] v);
		s_axis_tvalid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (90) @(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	initial begin
		@(negedge clk);
		while (!run_done) begin
			if (!hold_off && $urandom_range(0, 29) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(10, 40)) @(negedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(0, 3) != 0) && !hold_off;
				@(negedge clk);
			end
		end
	end

	initial begin
		logic [16:0] thr[5];
		logic [167:0] d;
		int wait_cnt;
		thr = '{17'd0, 17'd65536, 17'd32768, 17'($urandom_range(0, 65536)), 17'd65529};
		repeat (4) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		d = '0;
		for (int b = 0; b < 18; b++) begin
			d = '0;
			for (int i = 0; i < 9; i++) d[18*i +: 18] = 18'd1 << b;
			if (b >= 16) d[144 +: 18] = 18'h8000;
			send_item(d);
		end
		send_item({18'h08000, 18'h0, 18'h0, 18'h0, 18'h10000, 18'h0, 18'h0, 18'h0, 18'h10000});
		send_item({18'h08000, 18'h0, 18'h0, 18'h0, 18'h30000, 18'h0, 18'h0, 18'h10000, 18'h0});
		send_item({18'h04000, 18'h0, 18'h0, 18'h10000, 18'h0, 18'h0, 18'h0, 18'h0, 18'h10000});
		send_item({18'h0, 18'h20000, 18'h20000, 18'h20000, 18'h20000, 18'h1FFFF, 18'h1FFFF,
			18'h1FFFF, 18'h1FFFF});
		hold_off = 1;
		fork
			begin
				repeat (150) @(negedge clk);
				hold_off = 0;
			end
			for (int n = 0; n < 80; n++) send_item(make_item($urandom_range(0, 1)));
		join
		for (int ph = 0; ph < 5; ph++) begin
			write_thresh(thr[ph]);
			for (int n = 0; n < 240; n++) send_item(make_item($urandom_range(0, 2) == 0));
		end
		s_axis_tvalid <= 0;
		wait_cnt = 0;
		while (pending != 0 && wait_cnt < 200000) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (100) @(negedge clk);
		run_done = 1;
		if (fail_count == 0 && pending == 0) begin
			$display("quaternion_slerp regression: pass");
		end else begin
			$display("quaternion_slerp regression: fail");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("quaternion_slerp regression: fail");
		$finish;
	end
endmodule

[files.f]
sv/qslerp_pkg.sv
sv/qslerp_sqrt.sv
sv/qslerp_cordic.sv
sv/qslerp_div.sv
sv/quaternion_slerp.sv
tb/quaternion_slerp_checker.sv
tb/quaternion_slerp_tb.sv
